### src/serial_load_bank_mapper_core_defines.svh
// Assertion shorthands used by the RTL core. Clock is clk_i, reset is rst_ni.
`ifndef SERIAL_LOAD_BANK_MAPPER_CORE_DEFINES_SVH
`define SERIAL_LOAD_BANK_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SLBM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slbm assertion failed");

// Next-cycle implication, disabled in reset.
`define SLBM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slbm assertion failed");

`endif

### src/slbm_pkg.sv
package slbm_pkg;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 8;
  localparam int unsigned BankW  = 5;
  localparam int unsigned MirrW  = 2;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CntW   = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPrgBankCount    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgInitialMirroring = 1'd1;

  localparam logic [CntW-1:0]   ShiftBits      = 3'd5;
  localparam logic [BankW-1:0]  CtrlReset      = 5'd12;
  localparam logic [CountW-1:0] BankCountReset = 6'd2;
  localparam logic [MirrW-1:0]  MirrReset      = 2'd2;

  // target register chosen by address bits 14-13
  typedef enum logic [1:0] {
    TgtControl = 2'd0,
    TgtChrLow  = 2'd1,
    TgtChrHigh = 2'd2,
    TgtPrg     = 2'd3
  } target_e;

  // PRG mode, control bits 3-2
  typedef enum logic [1:0] {
    PrgSwap32A  = 2'd0,
    PrgSwap32B  = 2'd1,
    PrgFixFirst = 2'd2,
    PrgFixLast  = 2'd3
  } prg_mode_e;

  typedef struct packed {
    logic [BankW-1:0] shift_value;
    logic [CntW-1:0]  shift_count;
    logic [BankW-1:0] control_value;
    logic [BankW-1:0] prg_select;
    logic [BankW-1:0] prg_low_slot;
    logic [BankW-1:0] prg_high_slot;
    logic [BankW-1:0] chr_low_slot;
    logic [BankW-1:0] chr_high_slot;
    logic [MirrW-1:0] mirror_mode;
  } map_state_t;

  // highest bank, bank count minus one modulo 32
  function automatic logic [BankW-1:0] last_bank(input logic [CountW-1:0] count);
    logic [CountW-1:0] m1;
    m1 = count - 6'd1;
    return m1[BankW-1:0];
  endfunction

endpackage

### src/slbm_if.sv
interface slbm_in_if import slbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] write_address;
  logic [DataW-1:0] write_data;

  modport source (output valid, write_address, write_data, input ready);
  modport sink (input valid, write_address, write_data, output ready);
endinterface

interface slbm_out_if import slbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BankW-1:0] prg_low_bank;
  logic [BankW-1:0] prg_high_bank;
  logic [BankW-1:0] chr_low_bank;
  logic [BankW-1:0] chr_high_bank;
  logic [MirrW-1:0] mirroring;
  logic             register_committed;

  modport source (output valid, prg_low_bank, prg_high_bank, chr_low_bank, chr_high_bank,
                  mirroring, register_committed, input ready);
  modport sink (input valid, prg_low_bank, prg_high_bank, chr_low_bank, chr_high_bank,
                mirroring, register_committed, output ready);
endinterface

### src/serial_load_bank_mapper_core.sv
// Serial-load bank mapper. Each input item is one CPU write to cartridge
// space; every item gives exactly one result item carrying the current PRG
// (16KB) and CHR (4KB) slot bank numbers, the mirroring code, and a flag that
// is set when the write completed a five-bit register load. Writes with
// address bit 15 clear leave the mapper unchanged. Throughput is one item
// per clock while results are taken; each result is registered behind
// the input (one input register, then the state update and result
// register). A second item can sit in the input register while a result
// waits to be taken. The configuration port (bank count, initial
// mirroring) must be written only while no item is in flight; writing a
// register also reloads the fixed last PRG slot or the mirroring, as on
// cartridge load.
`include "serial_load_bank_mapper_core_defines.svh"

module serial_load_bank_mapper_core import slbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  slbm_in_if.sink            in_i,
  slbm_out_if.source         out_o
);

  // input register
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;
  logic             s1_advance;

  // mapper state and configuration
  map_state_t        state_q, state_d;
  logic [CountW-1:0] bank_count_q;
  logic              committed;

  // result register
  logic             out_valid_q;
  logic [BankW-1:0] prg_low_q, prg_high_q, chr_low_q, chr_high_q;
  logic [MirrW-1:0] mirr_q;
  logic             committed_q;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_addr_q <= in_i.write_address;
      s1_data_q <= in_i.write_data;
    end
  end

  slbm_update u_update (
    .state_i          (state_q),
    .prg_bank_count_i (bank_count_q),
    .write_address_i  (s1_addr_q),
    .write_data_i     (s1_data_q),
    .state_o          (state_d),
    .committed_o      (committed)
  );

  // State: config writes are for the user to make only while idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q          <= BankCountReset;
      state_q.shift_value   <= '0;
      state_q.shift_count   <= '0;
      state_q.control_value <= CtrlReset;
      state_q.prg_select    <= '0;
      state_q.prg_low_slot  <= '0;
      state_q.prg_high_slot <= last_bank(BankCountReset);
      state_q.chr_low_slot  <= '0;
      state_q.chr_high_slot <= 5'd1;
      state_q.mirror_mode   <= MirrReset;
    end else begin
      priority if (cfg_we_i && cfg_idx_i == CfgPrgBankCount) begin
        bank_count_q          <= cfg_data_i;
        state_q.prg_high_slot <= last_bank(cfg_data_i);
      end else if (cfg_we_i && cfg_idx_i == CfgInitialMirroring) begin
        state_q.mirror_mode <= cfg_data_i[MirrW-1:0];
      end else if (s1_advance) begin
        state_q <= state_d;
      end else begin
        state_q <= state_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      prg_low_q   <= state_d.prg_low_slot;
      prg_high_q  <= state_d.prg_high_slot;
      chr_low_q   <= state_d.chr_low_slot;
      chr_high_q  <= state_d.chr_high_slot;
      mirr_q      <= state_d.mirror_mode;
      committed_q <= committed;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.prg_low_bank       = prg_low_q;
  assign out_o.prg_high_bank      = prg_high_q;
  assign out_o.chr_low_bank       = chr_low_q;
  assign out_o.chr_high_bank      = chr_high_q;
  assign out_o.mirroring          = mirr_q;
  assign out_o.register_committed = committed_q;

  `SLBM_ASSERT_IMP(a_shift_count_range, 1'b1, state_q.shift_count < ShiftBits)
  `SLBM_ASSERT_NXT(a_commit_clears_load, s1_advance && committed, state_q.shift_count == '0)
  `SLBM_ASSERT_NXT(a_low_addr_no_change, s1_advance && !s1_addr_q[AddrW-1] && !cfg_we_i,
                   $stable(state_q))
  `SLBM_ASSERT_IMP(a_result_from_stage, $rose(out_valid_q), $past(s1_valid_q))

endmodule

### src/slbm_update.sv
// Next mapper state for one CPU write.
module slbm_update import slbm_pkg::*; (
  input  map_state_t        state_i,
  input  logic [CountW-1:0] prg_bank_count_i,
  input  logic [AddrW-1:0]  write_address_i,
  input  logic [DataW-1:0]  write_data_i,
  output map_state_t        state_o,
  output logic              committed_o
);

  typedef struct packed {
    logic [BankW-1:0] low;
    logic [BankW-1:0] high;
  } prg_slots_t;

  function automatic prg_slots_t remap(input logic [BankW-1:0] ctrl,
                                       input logic [BankW-1:0] sel,
                                       input logic [BankW-1:0] last);
    prg_slots_t s;
    unique case (prg_mode_e'(ctrl[3:2]))
      PrgFixFirst: begin
        s.low  = '0;
        s.high = sel;
      end
      PrgFixLast: begin
        s.low  = sel;
        s.high = last;
      end
      PrgSwap32A, PrgSwap32B: begin
        s.low  = {sel[BankW-1:1], 1'b0};
        s.high = {sel[BankW-1:1], 1'b1};
      end
      default: begin
        s.low  = sel;
        s.high = last;
      end
    endcase
    return s;
  endfunction

  logic [BankW-1:0] load;
  logic [CntW-1:0]  cnt_inc;
  logic [BankW-1:0] last;
  target_e          tgt;
  prg_slots_t       slots;

  always_comb begin
    load    = state_i.shift_value | (BankW'(write_data_i[0]) << state_i.shift_count);
    cnt_inc = state_i.shift_count + 3'd1;
    last    = last_bank(prg_bank_count_i);
    tgt     = target_e'(write_address_i[14:13]);
    slots   = '0;
    state_o = state_i;
    committed_o = 1'b0;
    if (write_address_i[AddrW-1]) begin
      if (write_data_i[DataW-1]) begin
        // load reset: PRG mode forced to fix-last, slots untouched
        state_o.shift_value = '0;
        state_o.shift_count = '0;
        state_o.control_value[3:2] = PrgFixLast;
      end else if (cnt_inc >= ShiftBits) begin
        state_o.shift_value = '0;
        state_o.shift_count = '0;
        committed_o = 1'b1;
        unique case (tgt)
          TgtControl: begin
            state_o.mirror_mode = load[1:0];
            if (state_i.control_value[3:2] != load[3:2]) begin
              slots = remap(load, state_i.prg_select, last);
              state_o.prg_low_slot  = slots.low;
              state_o.prg_high_slot = slots.high;
            end
            state_o.control_value = load;
          end
          TgtChrLow: begin
            if (state_i.control_value[4]) begin
              state_o.chr_low_slot = load;
            end else begin
              state_o.chr_low_slot  = {load[BankW-1:1], 1'b0};
              state_o.chr_high_slot = {load[BankW-1:1], 1'b1};
            end
          end
          TgtChrHigh: begin
            if (state_i.control_value[4]) begin
              state_o.chr_high_slot = load;
            end
          end
          TgtPrg: begin
            state_o.prg_select = load;
            slots = remap(state_i.control_value, load, last);
            state_o.prg_low_slot  = slots.low;
            state_o.prg_high_slot = slots.high;
          end
          default: begin
            state_o.prg_select = load;
          end
        endcase
      end else begin
        state_o.shift_value = load;
        state_o.shift_count = cnt_inc;
      end
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

// Bank mapper bench: directed writes, then random load sequences over several
// register settings and idle mixes. Each accepted write is run through a local
// mapper model; the result items are compared field by field in order.
module testbench import slbm_pkg::*; ();

  // cycles with no item moving before the run is called hung
  localparam int unsigned StallLimit = 4000;
  // long receiver hold-off, so the block fills and stalls its input
  localparam int unsigned HoldOffLen = 300;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } cpu_write_t;

  typedef struct packed {
    logic [BankW-1:0] prg_lo;
    logic [BankW-1:0] prg_hi;
    logic [BankW-1:0] chr_lo;
    logic [BankW-1:0] chr_hi;
    logic [MirrW-1:0] mirr;
    logic             committed;
  } bank_view_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  slbm_in_if  cpu_bus ();
  slbm_out_if map_bus ();

  serial_load_bank_mapper_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (cpu_bus),
    .out_o     (map_bus)
  );

  // stimulus and expectations
  cpu_write_t pending_writes[$];
  bank_view_t expected_views[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  bit          cpu_taken;

  // mapper model state
  logic [BankW-1:0]  ld_shift;
  logic [CntW-1:0]   ld_count;
  logic [BankW-1:0]  ctrl_reg;
  logic [BankW-1:0]  prg_sel;
  logic [BankW-1:0]  prg_lo;
  logic [BankW-1:0]  prg_hi;
  logic [BankW-1:0]  chr_lo;
  logic [BankW-1:0]  chr_hi;
  logic [MirrW-1:0]  mirr;
  logic [CountW-1:0] bank_count;
  logic [MirrW-1:0]  init_mirr;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Mapper model
  // ---------------------------------------------------------------------

  // fixed last bank: count minus one, wrapped to five bits (count 0 -> 31)
  function automatic logic [BankW-1:0] fixed_bank();
    logic [CountW-1:0] m1;
    m1 = bank_count - 6'd1;
    return m1[BankW-1:0];
  endfunction

  // recompute both PRG slots from the mode bits and the PRG select
  task automatic remap_prg_slots();
    case (prg_mode_e'(ctrl_reg[3:2]))
      PrgFixFirst: begin
        prg_lo = '0;
        prg_hi = prg_sel;
      end
      PrgFixLast: begin
        prg_lo = prg_sel;
        prg_hi = fixed_bank();
      end
      default: begin
        // 32KB mode: even/odd pair, low bit of the select dropped
        prg_lo = {prg_sel[BankW-1:1], 1'b0};
        prg_hi = {prg_sel[BankW-1:1], 1'b1};
      end
    endcase
  endtask

  // one CPU write into the model; returns the bank view it reports
  task automatic map_cpu_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data,
                               output bank_view_t view);
    logic             done;
    logic [BankW-1:0] v;
    done = 1'b0;
    if (addr[15]) begin
      if (data[7]) begin
        // load reset: clear the shift, force PRG mode to fix-last, no remap
        ld_shift = '0;
        ld_count = '0;
        ctrl_reg[3:2] = PrgFixLast;
      end else begin
        ld_shift[ld_count] = data[0];
        ld_count = ld_count + 3'd1;
        if (ld_count == ShiftBits) begin
          v = ld_shift;
          case (target_e'(addr[14:13]))
            TgtControl: begin
              mirr = v[1:0];
              // remap only if the mode bits actually change
              if (ctrl_reg[3:2] != v[3:2]) begin
                ctrl_reg = v;
                remap_prg_slots();
              end
              ctrl_reg = v;
            end
            TgtChrLow: begin
              if (ctrl_reg[4]) begin
                chr_lo = v;
              end else begin
                // 8KB CHR mode sets both slots as a pair
                chr_lo = {v[BankW-1:1], 1'b0};
                chr_hi = {v[BankW-1:1], 1'b1};
              end
            end
            TgtChrHigh: begin
              // ignored in 8KB CHR mode
              if (ctrl_reg[4]) chr_hi = v;
            end
            default: begin
              prg_sel = v;
              remap_prg_slots();
            end
          endcase
          ld_shift = '0;
          ld_count = '0;
          done = 1'b1;
        end
      end
    end
    view = '{prg_lo: prg_lo, prg_hi: prg_hi, chr_lo: chr_lo, chr_hi: chr_hi,
             mirr: mirr, committed: done};
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_view(input bank_view_t got, input bank_view_t want);
    if (got.prg_lo !== want.prg_lo)
      report_mismatch("prg_low_bank", int'(got.prg_lo), int'(want.prg_lo));
    if (got.prg_hi !== want.prg_hi)
      report_mismatch("prg_high_bank", int'(got.prg_hi), int'(want.prg_hi));
    if (got.chr_lo !== want.chr_lo)
      report_mismatch("chr_low_bank", int'(got.chr_lo), int'(want.chr_lo));
    if (got.chr_hi !== want.chr_hi)
      report_mismatch("chr_high_bank", int'(got.chr_hi), int'(want.chr_hi));
    if (got.mirr !== want.mirr)
      report_mismatch("mirroring", int'(got.mirr), int'(want.mirr));
    if (got.committed !== want.committed)
      report_mismatch("register_committed", int'(got.committed), int'(want.committed));
  endtask

  // Monitor, sampled at the rising edge. The result taken at this edge is
  // always for an earlier write (the block registers its input), so the
  // check runs before the new write is pushed.
  always @(posedge clk) begin
    bank_view_t got;
    bank_view_t want;
    if (rst_n) begin
      if (map_bus.valid && map_bus.ready) begin
        got = '{prg_lo: map_bus.prg_low_bank, prg_hi: map_bus.prg_high_bank,
                chr_lo: map_bus.chr_low_bank, chr_hi: map_bus.chr_high_bank,
                mirr: map_bus.mirroring, committed: map_bus.register_committed};
        if (expected_views.size() == 0) begin
          report_mismatch("result with nothing expected", int'(got), 0);
        end else begin
          want = expected_views.pop_front();
          check_view(got, want);
        end
      end
      if (cpu_bus.valid && cpu_bus.ready) begin
        map_cpu_write(cpu_bus.write_address, cpu_bus.write_data, want);
        expected_views.push_back(want);
        cpu_taken = 1'b1;
      end
    end
  end

  // Watchdog: any item moving (or a register write) clears the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cpu_bus.valid && cpu_bus.ready) || (map_bus.valid && map_bus.ready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------

  // Holds the current item until the monitor flags it taken, then offers
  // the next one or idles. valid is assigned once per step.
  always @(negedge clk) begin
    cpu_write_t w;
    if (rst_n && (!cpu_bus.valid || cpu_taken)) begin
      if (pending_writes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_writes.pop_front();
        cpu_bus.valid         <= 1'b1;
        cpu_bus.write_address <= w.addr;
        cpu_bus.write_data    <= w.data;
      end else begin
        cpu_bus.valid <= 1'b0;
      end
    end
    cpu_taken = 1'b0;
  end

  // receiver ready: random stalls, plus the long hold-off when armed
  always @(negedge clk) begin
    map_bus.ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // hold-off counter, counted down in cycles here
  always @(negedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic int unsigned queue_write(input logic [AddrW-1:0] addr,
                                              input logic [DataW-1:0] data);
    pending_writes.push_back('{addr: addr, data: data});
    return addr[15] ? 1 : 0;
  endfunction

  // five serial writes; only the last address picks the target
  function automatic int unsigned queue_load(input target_e tgt, input logic [BankW-1:0] val);
    logic [AddrW-1:0] a;
    logic [DataW-1:0] d;
    for (int i = 0; i < 5; i++) begin
      a = {1'b1, 15'($urandom)};
      if (i == 4) a[14:13] = tgt;
      d = {1'b0, 6'($urandom), val[i]};
      pending_writes.push_back('{addr: a, data: d});
    end
    return 5;
  endfunction

  // random mix: mostly complete loads, some stray bits, load resets and
  // writes outside cartridge space (those do not count)
  task automatic queue_random(input int unsigned n);
    int unsigned cnt;
    int unsigned r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        if ($urandom_range(1)) cnt += queue_write({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
        cnt += queue_load(target_e'($urandom_range(3)), 5'($urandom));
      end else if (r < 82) begin
        cnt += queue_write({1'b1, 15'($urandom)}, 8'($urandom));
      end else if (r < 90) begin
        cnt += queue_write({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
      end else begin
        void'(queue_write({1'b0, 15'($urandom)}, 8'($urandom)));
      end
    end
  endtask

  // wait until every write is in and every result is out, then let the
  // two-stage pipe settle
  task automatic wait_drained();
    while (pending_writes.size() != 0 || expected_views.size() != 0 || cpu_bus.valid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // register write while idle; the model reloads as the block does
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CfgPrgBankCount) begin
      bank_count = val;
      prg_hi = fixed_bank();
    end else begin
      init_mirr = val[MirrW-1:0];
      mirr = init_mirr;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [CfgW-1:0] count, input logic [CfgW-1:0] mirr_val,
                           input int unsigned n);
    wait_drained();
    write_reg(CfgPrgBankCount, count);
    write_reg(CfgInitialMirroring, mirr_val);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_data              = '0;
    cpu_bus.valid         = 1'b0;
    cpu_bus.write_address = '0;
    cpu_bus.write_data    = '0;
    map_bus.ready         = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_left             = 0;
    idle_cycles           = 0;
    error_count           = 0;
    cpu_taken             = 1'b0;

    // model at reset
    bank_count = BankCountReset;
    init_mirr  = MirrReset;
    ld_shift   = '0;
    ld_count   = '0;
    ctrl_reg   = CtrlReset;
    prg_sel    = '0;
    prg_lo     = '0;
    prg_hi     = fixed_bank();
    chr_lo     = '0;
    chr_hi     = 5'd1;
    mirr       = init_mirr;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings, no idling
    void'(queue_write(16'h7fff, 8'hff));       // below cartridge space: ignored
    void'(queue_write(16'h8000, 8'h80));       // load reset, no remap
    void'(queue_load(TgtControl, 5'b10011));   // 4KB CHR, 32KB PRG, mirroring 3
    void'(queue_load(TgtChrLow, 5'd31));
    void'(queue_load(TgtChrHigh, 5'd0));
    void'(queue_load(TgtPrg, 5'd31));
    // load reset in the middle of a sequence, then a full load after it
    void'(queue_write(16'hffff, 8'h01));
    void'(queue_write(16'hffff, 8'h7f));
    void'(queue_write(16'hc000, 8'hff));
    void'(queue_load(TgtPrg, 5'd0));

    // random phases over register settings, bank count extremes among them
    run_phase(0, 0, 6'd1, 6'd0, 120);
    run_phase(81, 0, 6'd32, 6'd3, 120);
    run_phase(0, 81, 6'd0, 6'd1, 120);
    run_phase(34, 34, 6'd63, 6'b111110, 120);

    // pressure: receiver holds off while the sender keeps offering items
    wait_drained();
    write_reg(CfgPrgBankCount, 6'($urandom));
    write_reg(CfgInitialMirroring, 6'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HoldOffLen;
    queue_random(120);

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/slbm_pkg.sv
src/slbm_if.sv
src/slbm_update.sv
src/serial_load_bank_mapper_core.sv
dv/testbench.sv
